/* rtl/bpfa_pkg.sv */
// Package: constants, types and helper functions of the bitmap page frame allocator.
`timescale 1ns / 1ps
`default_nettype none
package bpfa_pkg;

    localparam int TOTAL_FRAMES    = 32768;
    localparam int RESERVED_FRAMES = 16384;
    localparam int PAGE_SHIFT      = 12;

    localparam int RES_EFF = (RESERVED_FRAMES < TOTAL_FRAMES) ? RESERVED_FRAMES : TOTAL_FRAMES;

    localparam int WORD_BITS = 32;
    localparam int BIT_W     = 5;
    localparam int WORDS     = (TOTAL_FRAMES + WORD_BITS - 1) / WORD_BITS;
    localparam int AW        = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int FIDX_W    = AW + BIT_W;
    localparam int CNT_W     = $clog2(TOTAL_FRAMES + 1);
    localparam int RUN_W     = ((CNT_W > 16) ? CNT_W : 16) + 1;
    localparam int POP_W     = BIT_W + 1;
    localparam int EXT_W     = 33;

    localparam int MODE_W     = 2;
    localparam int ADDR_W     = 32;
    localparam int COUNT_W    = 16;
    localparam int STATUS_W   = 2;
    localparam int RUN_ADDR_W = 27;
    localparam int FCOUNT_W   = 16;
    localparam int PAGE_W     = ADDR_W - PAGE_SHIFT;

    typedef logic [MODE_W-1:0] t_mode;
    localparam t_mode MODE_ALLOC    = 2'd0;
    localparam t_mode MODE_FREE_ONE = 2'd1;
    localparam t_mode MODE_FREE_RUN = 2'd2;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK      = 2'd0,
        STAT_INVALID = 2'd1,
        STAT_NO_RUN  = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_INIT,
        S_IDLE,
        S_SCAN,
        S_UPDATE
    } t_state;

    typedef struct packed {
        logic                 we;
        logic [AW-1:0]        waddr;
        logic [WORD_BITS-1:0] wdata;
        logic [AW-1:0]        raddr;
    } t_mem_req;

    typedef struct packed {
        logic             hit;
        logic [BIT_W-1:0] pos;
        logic [RUN_W-1:0] run;
    } t_find;

    // Reset contents of one bitmap word; frames past the end read as used.
    function automatic logic [WORD_BITS-1:0] init_word(input logic [AW-1:0] k);
        logic [WORD_BITS-1:0] w;
        int                   idx;
        w = '0;
        for (int i = 0; i < WORD_BITS; i++) begin
            idx  = int'(k) * WORD_BITS + i;
            w[i] = (idx < RES_EFF) || (idx >= TOTAL_FRAMES);
        end
        return w;
    endfunction

    function automatic logic [WORD_BITS-1:0] word_mask(input logic [BIT_W-1:0] lo,
                                                       input logic [BIT_W-1:0] hi);
        logic [WORD_BITS-1:0] ones;
        logic [BIT_W-1:0]     top_gap;
        ones    = '1;
        top_gap = BIT_W'(WORD_BITS - 1) - hi;
        return (ones << lo) & (ones >> top_gap);
    endfunction

endpackage
`default_nettype wire

/* rtl/bitmap_page_frame_allocator_unit.sv */
// Top level: bitmap page frame allocator with first-fit run search.
// Invalid requests are answered from idle without going busy; a free updates each word it spans;
// an allocate scans one 32-frame bitmap word read per cycle, then on a miss reports no run
// or marks the run word by word.
// One request at a time; busy stays high until the result beat, which cannot be stalled.
// After reset the bitmap is swept to its reserved pattern, one word a cycle, with busy high throughout.
`timescale 1ns / 1ps
`default_nettype none
module bitmap_page_frame_allocator_unit (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             start,
    output logic                                  busy,
    input  wire logic [bpfa_pkg::MODE_W-1:0]      i_mode,
    input  wire logic [bpfa_pkg::ADDR_W-1:0]      i_address,
    input  wire logic [bpfa_pkg::COUNT_W-1:0]     i_count,
    output logic                                  o_valid,
    output logic [bpfa_pkg::STATUS_W-1:0]         o_status,
    output logic [bpfa_pkg::RUN_ADDR_W-1:0]       o_run_address,
    output logic [bpfa_pkg::FCOUNT_W-1:0]         o_free_count,
    output logic [bpfa_pkg::FCOUNT_W-1:0]         o_used_count
);
    import bpfa_pkg::*;

    t_state               r_state, n_state;
    logic [AW:0]          r_addr, n_addr;
    logic                 r_pend, n_pend;
    logic [AW-1:0]        r_proc, n_proc;
    logic [RUN_W-1:0]     r_run, n_run;
    logic [COUNT_W-1:0]   r_count, n_count;
    logic [AW-1:0]        r_first_word, n_first_word;
    logic [AW-1:0]        r_last_word, n_last_word;
    logic [BIT_W-1:0]     r_lo_bit, n_lo_bit;
    logic [BIT_W-1:0]     r_hi_bit, n_hi_bit;
    logic                 r_set, n_set;
    logic                 r_strict, n_strict;
    logic [FIDX_W-1:0]    r_start, n_start;
    logic [CNT_W-1:0]     r_free, n_free;
    logic                 r_valid, n_valid;
    t_status              r_status, n_status;
    logic [RUN_ADDR_W-1:0] r_run_addr, n_run_addr;

    t_mem_req             mem_req;
    logic [WORD_BITS-1:0] rd_data;
    t_find                find;

    logic                 accept;
    logic [PAGE_W-1:0]    page;
    logic [EXT_W-1:0]     run_end_ext;
    logic                 alloc_ok;
    logic                 free_one_ok;
    logic                 free_run_ok;
    logic                 scan_hit;
    logic                 scan_end;
    logic [FIDX_W-1:0]    hit_frame;
    logic [FIDX_W-1:0]    hit_start;
    logic [WORD_BITS-1:0] upd_mask;
    logic [POP_W-1:0]     upd_pop;
    logic                 upd_last;
    logic                 issue_ok;

    bpfa_mark_mem u_mem (
        .i_clk     (i_clk),
        .i_req     (mem_req),
        .o_rd_data (rd_data)
    );

    bpfa_run_find u_find (
        .i_word  (rd_data),
        .i_run   (r_run),
        .i_count (r_count),
        .o_find  (find)
    );

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;
    assign page   = i_address[ADDR_W-1:PAGE_SHIFT];

    assign run_end_ext = EXT_W'(page) + EXT_W'(i_count);
    assign alloc_ok    = (i_count != '0);
    assign free_one_ok = (i_address != '0) && (EXT_W'(page) < EXT_W'(TOTAL_FRAMES));
    assign free_run_ok = (i_address != '0) && (i_count != '0)
                         && (run_end_ext <= EXT_W'(TOTAL_FRAMES));

    assign scan_hit  = r_pend && find.hit;
    assign scan_end  = r_pend && !find.hit && (r_proc == AW'(WORDS - 1));
    assign hit_frame = {r_proc, find.pos};
    assign hit_start = FIDX_W'(RUN_W'(hit_frame) + RUN_W'(1) - RUN_W'(r_count));

    assign upd_mask = word_mask((r_proc == r_first_word) ? r_lo_bit : '0,
                                (r_proc == r_last_word) ? r_hi_bit : BIT_W'(WORD_BITS - 1));
    assign upd_pop  = POP_W'($countones(rd_data & upd_mask));
    assign upd_last = r_pend && (r_proc == r_last_word);
    assign issue_ok = (r_addr <= {1'b0, r_last_word});

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_INIT: begin
                if (r_addr[AW-1:0] == AW'(WORDS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    unique case (i_mode)
                        MODE_ALLOC:    n_state = alloc_ok ? S_SCAN : S_IDLE;
                        MODE_FREE_ONE: n_state = free_one_ok ? S_UPDATE : S_IDLE;
                        MODE_FREE_RUN: n_state = free_run_ok ? S_UPDATE : S_IDLE;
                        default:       n_state = S_IDLE;
                    endcase
                end
            end
            S_SCAN: begin
                priority if (scan_hit) begin
                    n_state = S_UPDATE;
                end else if (scan_end) begin
                    n_state = S_IDLE;
                end
            end
            S_UPDATE: begin
                if (upd_last) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_addr       = r_addr;
        n_pend       = 1'b0;
        n_proc       = r_proc;
        n_run        = r_run;
        n_count      = r_count;
        n_first_word = r_first_word;
        n_last_word  = r_last_word;
        n_lo_bit     = r_lo_bit;
        n_hi_bit     = r_hi_bit;
        n_set        = r_set;
        n_strict     = r_strict;
        n_start      = r_start;
        n_free       = r_free;
        n_valid      = 1'b0;
        n_status     = r_status;
        n_run_addr   = r_run_addr;
        mem_req      = '0;
        mem_req.raddr = r_addr[AW-1:0];

        unique case (r_state)
            S_INIT: begin
                mem_req.we    = 1'b1;
                mem_req.waddr = r_addr[AW-1:0];
                mem_req.wdata = init_word(r_addr[AW-1:0]);
                n_addr        = r_addr + 1'b1;
            end
            S_IDLE: begin
                if (accept) begin
                    n_count    = i_count;
                    n_addr     = '0;
                    n_run      = '0;
                    n_set      = 1'b0;
                    n_strict   = (i_mode == MODE_FREE_ONE);
                    n_start    = FIDX_W'(page);
                    n_lo_bit   = page[BIT_W-1:0];
                    n_first_word = page[FIDX_W-1:BIT_W];
                    n_run_addr = '0;
                    unique case (i_mode)
                        MODE_ALLOC: begin
                            if (!alloc_ok) begin
                                n_valid  = 1'b1;
                                n_status = STAT_INVALID;
                            end
                        end
                        MODE_FREE_ONE: begin
                            n_addr      = {1'b0, page[FIDX_W-1:BIT_W]};
                            n_last_word = page[FIDX_W-1:BIT_W];
                            n_hi_bit    = page[BIT_W-1:0];
                            if (!free_one_ok) begin
                                n_valid  = 1'b1;
                                n_status = STAT_INVALID;
                            end
                        end
                        MODE_FREE_RUN: begin
                            n_addr      = {1'b0, page[FIDX_W-1:BIT_W]};
                            n_last_word = run_end_ext[FIDX_W-1:BIT_W] - AW'(run_end_ext[BIT_W-1:0] == '0);
                            n_hi_bit    = BIT_W'(run_end_ext[BIT_W-1:0] - 1'b1);
                            if (!free_run_ok) begin
                                n_valid  = 1'b1;
                                n_status = STAT_INVALID;
                            end
                        end
                        default: begin
                            n_valid  = 1'b1;
                            n_status = STAT_INVALID;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (r_addr < (AW + 1)'(WORDS)) begin
                    n_addr = r_addr + 1'b1;
                    n_pend = 1'b1;
                end
                n_proc = r_addr[AW-1:0];
                if (r_pend) begin
                    n_run = find.run;
                end
                priority if (scan_hit) begin
                    n_start      = hit_start;
                    n_first_word = hit_start[FIDX_W-1:BIT_W];
                    n_lo_bit     = hit_start[BIT_W-1:0];
                    n_last_word  = r_proc;
                    n_hi_bit     = find.pos;
                    n_set        = 1'b1;
                    n_strict     = 1'b0;
                    n_addr       = {1'b0, hit_start[FIDX_W-1:BIT_W]};
                    n_pend       = 1'b0;
                end else if (scan_end) begin
                    n_valid    = 1'b1;
                    n_status   = STAT_NO_RUN;
                    n_run_addr = '0;
                end
            end
            S_UPDATE: begin
                if (issue_ok) begin
                    n_addr = r_addr + 1'b1;
                    n_pend = 1'b1;
                end
                n_proc = r_addr[AW-1:0];
                if (r_pend) begin
                    mem_req.we    = 1'b1;
                    mem_req.waddr = r_proc;
                    mem_req.wdata = r_set ? (rd_data | upd_mask) : (rd_data & ~upd_mask);
                    if (!r_set) begin
                        n_free = r_free + CNT_W'(upd_pop);
                    end
                end
                if (upd_last) begin
                    n_pend  = 1'b0;
                    n_valid = 1'b1;
                    if (r_set) begin
                        n_free     = r_free - CNT_W'(r_count);
                        n_status   = STAT_OK;
                        n_run_addr = RUN_ADDR_W'(r_start) << PAGE_SHIFT;
                    end else begin
                        n_status   = (r_strict && (upd_pop == '0)) ? STAT_INVALID : STAT_OK;
                        n_run_addr = '0;
                    end
                end
            end
            default: begin
                n_pend = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_addr  <= '0;
            r_pend  <= 1'b0;
            r_free  <= CNT_W'(TOTAL_FRAMES - RES_EFF);
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_addr  <= n_addr;
            r_pend  <= n_pend;
            r_free  <= n_free;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_proc       <= n_proc;
        r_run        <= n_run;
        r_count      <= n_count;
        r_first_word <= n_first_word;
        r_last_word  <= n_last_word;
        r_lo_bit     <= n_lo_bit;
        r_hi_bit     <= n_hi_bit;
        r_set        <= n_set;
        r_strict     <= n_strict;
        r_start      <= n_start;
        r_status     <= n_status;
        r_run_addr   <= n_run_addr;
    end

    assign o_valid       = r_valid;
    assign o_status      = r_status;
    assign o_run_address = r_run_addr;
    assign o_free_count  = FCOUNT_W'(r_free);
    assign o_used_count  = FCOUNT_W'(CNT_W'(TOTAL_FRAMES) - r_free);

endmodule
`default_nettype wire

/* rtl/bpfa_mark_mem.sv */
// Bitmap store: one write port, one read port with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module bpfa_mark_mem (
    input  wire logic                          i_clk,
    input  wire bpfa_pkg::t_mem_req            i_req,
    output logic [bpfa_pkg::WORD_BITS-1:0]     o_rd_data
);
    import bpfa_pkg::*;

    logic [WORD_BITS-1:0] r_mem [WORDS];

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rd_data <= r_mem[i_req.raddr];
    end

endmodule
`default_nettype wire

/* rtl/bpfa_run_find.sv */
// First-fit run detector over one bitmap word, carrying the free run from the word below.
`timescale 1ns / 1ps
`default_nettype none
module bpfa_run_find (
    input  wire logic [bpfa_pkg::WORD_BITS-1:0] i_word,
    input  wire logic [bpfa_pkg::RUN_W-1:0]     i_run,
    input  wire logic [bpfa_pkg::COUNT_W-1:0]   i_count,
    output bpfa_pkg::t_find                     o_find
);
    import bpfa_pkg::*;

    always_comb begin
        logic             all_free;
        logic [BIT_W-1:0] last;
        logic [RUN_W-1:0] run_i;
        all_free = 1'b1;
        last     = '0;
        run_i    = '0;
        o_find   = '0;
        for (int i = 0; i < WORD_BITS; i++) begin
            if (i_word[i]) begin
                all_free = 1'b0;
                last     = BIT_W'(i);
            end
            if (all_free) begin
                run_i = i_run + RUN_W'(i + 1);
            end else begin
                run_i = RUN_W'(BIT_W'(BIT_W'(i) - last));
            end
            if (!o_find.hit && (run_i >= RUN_W'(i_count))) begin
                o_find.hit = 1'b1;
                o_find.pos = BIT_W'(i);
            end
        end
        o_find.run = run_i;
    end

endmodule
`default_nettype wire

/* tb/bpfa_reply_checker.sv */
// Checker: bitmap allocator predictor and result beat comparison.
`timescale 1ns / 1ps
module bpfa_reply_checker (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_start,
    input  wire logic                            i_busy,
    input  wire logic [bpfa_pkg::MODE_W-1:0]     i_mode,
    input  wire logic [bpfa_pkg::ADDR_W-1:0]     i_address,
    input  wire logic [bpfa_pkg::COUNT_W-1:0]    i_count,
    input  wire logic                            i_valid,
    input  wire logic [bpfa_pkg::STATUS_W-1:0]   i_status,
    input  wire logic [bpfa_pkg::RUN_ADDR_W-1:0] i_run_address,
    input  wire logic [bpfa_pkg::FCOUNT_W-1:0]   i_free_count,
    input  wire logic [bpfa_pkg::FCOUNT_W-1:0]   i_used_count,
    output int                                   o_mismatches,
    output int                                   o_outstanding
);
    import bpfa_pkg::*;

    typedef struct packed {
        t_status                 status;
        logic [RUN_ADDR_W-1:0]   run_address;
        logic [FCOUNT_W-1:0]     free_count;
        logic [FCOUNT_W-1:0]     used_count;
    } t_frame_reply;

    logic         frame_used_map [TOTAL_FRAMES];
    int           free_frames;
    int           mismatches = 0;
    t_frame_reply pending_replies [$];

    task automatic resolve_frame_request(input t_mode mode, input logic [ADDR_W-1:0] addr,
                                         input logic [COUNT_W-1:0] cnt,
                                         output t_frame_reply rep);
        int      run;
        int      first;
        int      page;
        logic    found;
        t_status st;
        st              = STAT_INVALID;
        rep.run_address = '0;
        case (mode)
            MODE_ALLOC: begin
                if (cnt != 0) begin
                    run   = 0;
                    first = 0;
                    found = 1'b0;
                    for (int f = 0; f < TOTAL_FRAMES && !found; f++) begin
                        if (!frame_used_map[f]) begin
                            if (run == 0) first = f;
                            run++;
                            if (run == int'(cnt)) found = 1'b1;
                        end else begin
                            run = 0;
                        end
                    end
                    if (found) begin
                        for (int f = first; f < first + int'(cnt); f++) frame_used_map[f] = 1'b1;
                        free_frames     -= int'(cnt);
                        rep.run_address = RUN_ADDR_W'(first << PAGE_SHIFT);
                        st              = STAT_OK;
                    end else begin
                        st = STAT_NO_RUN;
                    end
                end
            end
            MODE_FREE_ONE: begin
                if (addr != 0) begin
                    page = int'(addr >> PAGE_SHIFT);
                    if (page < TOTAL_FRAMES && frame_used_map[page]) begin
                        frame_used_map[page] = 1'b0;
                        free_frames++;
                        st = STAT_OK;
                    end
                end
            end
            MODE_FREE_RUN: begin
                if (addr != 0 && cnt != 0) begin
                    page = int'(addr >> PAGE_SHIFT);
                    // no wraparound: page and count both fit an int comfortably
                    if (page + int'(cnt) <= TOTAL_FRAMES) begin
                        for (int f = page; f < page + int'(cnt); f++) begin
                            if (frame_used_map[f]) begin
                                frame_used_map[f] = 1'b0;
                                free_frames++;
                            end
                        end
                        st = STAT_OK;
                    end
                end
            end
            default: ;
        endcase
        rep.status     = st;
        rep.free_count = FCOUNT_W'(free_frames);
        rep.used_count = FCOUNT_W'(TOTAL_FRAMES - free_frames);
    endtask

    always @(posedge i_clk) begin
        t_frame_reply fresh;
        t_frame_reply want;
        if (!i_rst_n) begin
            for (int f = 0; f < TOTAL_FRAMES; f++) frame_used_map[f] = (f < RES_EFF);
            free_frames = TOTAL_FRAMES - RES_EFF;
            pending_replies.delete();
        end else begin
            if (i_start && !i_busy) begin
                resolve_frame_request(t_mode'(i_mode), i_address, i_count, fresh);
                pending_replies.push_back(fresh);
            end
            if (i_valid) begin
                if (pending_replies.size() == 0) begin
                    $error("result beat with no request outstanding");
                    mismatches++;
                end else begin
                    want = pending_replies.pop_front();
                    if (i_status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, i_status);
                        mismatches++;
                    end
                    if (i_run_address !== want.run_address) begin
                        $error("run_address: expected 0x%0h, got 0x%0h",
                               want.run_address, i_run_address);
                        mismatches++;
                    end
                    if (i_free_count !== want.free_count) begin
                        $error("free_count: expected %0d, got %0d",
                               want.free_count, i_free_count);
                        mismatches++;
                    end
                    if (i_used_count !== want.used_count) begin
                        $error("used_count: expected %0d, got %0d",
                               want.used_count, i_used_count);
                        mismatches++;
                    end
                end
            end
        end
        o_mismatches  <= mismatches;
        o_outstanding <= pending_replies.size();
    end

endmodule

/* tb/tb_bitmap_page_frame_allocator_unit.sv */
// Testbench top: request stimulus, clock, reset and verdict for the page frame allocator.
`timescale 1ns / 1ps
module tb_bitmap_page_frame_allocator_unit;
    import bpfa_pkg::*;

    // limit covers the worst beat plus a long sender gap for ~600 beats, several times over
    localparam int    CYCLE_LIMIT   = 8_000_000;
    localparam int    RANDOM_ITEMS  = 556;
    localparam t_mode MODE_RESERVED = 2'd3;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  start;
    logic                  busy;
    logic [MODE_W-1:0]     i_mode;
    logic [ADDR_W-1:0]     i_address;
    logic [COUNT_W-1:0]    i_count;
    logic                  o_valid;
    logic [STATUS_W-1:0]   o_status;
    logic [RUN_ADDR_W-1:0] o_run_address;
    logic [FCOUNT_W-1:0]   o_free_count;
    logic [FCOUNT_W-1:0]   o_used_count;
    int                    mismatches;
    int                    outstanding;
    int unsigned           cycles = 0;

    bitmap_page_frame_allocator_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_mode        (i_mode),
        .i_address     (i_address),
        .i_count       (i_count),
        .o_valid       (o_valid),
        .o_status      (o_status),
        .o_run_address (o_run_address),
        .o_free_count  (o_free_count),
        .o_used_count  (o_used_count)
    );

    bpfa_reply_checker checker_inst (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .i_busy        (busy),
        .i_mode        (i_mode),
        .i_address     (i_address),
        .i_count       (i_count),
        .i_valid       (o_valid),
        .i_status      (o_status),
        .i_run_address (o_run_address),
        .i_free_count  (o_free_count),
        .i_used_count  (o_used_count),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("** bitmap_page_frame_allocator_unit: FAILED **");
            $finish;
        end
    end

    function automatic logic [ADDR_W-1:0] frame_addr(input int frame, input int offset);
        return (ADDR_W'(frame) << PAGE_SHIFT) | ADDR_W'(offset);
    endfunction

    function automatic int pick_gap(input int idx);
        int r;
        if ((idx / 50) % 4 == 2) return 0;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 15);
        return $urandom_range(40, 150);
    endfunction

    task automatic issue(input t_mode m, input logic [ADDR_W-1:0] a,
                         input logic [COUNT_W-1:0] c, input int gap);
        start     <= 1'b1;
        i_mode    <= m;
        i_address <= a;
        i_count   <= c;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain_replies();
        start <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
    endtask

    task automatic pick_request(output t_mode m, output logic [ADDR_W-1:0] a,
                                output logic [COUNT_W-1:0] c);
        int r;
        int sz;
        int frame;
        r = $urandom_range(0, 99);
        if (r < 42) begin
            m  = MODE_ALLOC;
            a  = $urandom;
            sz = $urandom_range(0, 99);
            if (sz < 55)      c = COUNT_W'($urandom_range(1, 8));
            else if (sz < 85) c = COUNT_W'($urandom_range(9, 128));
            else if (sz < 96) c = COUNT_W'($urandom_range(129, 2048));
            else              c = COUNT_W'($urandom_range(2049, 40000));
        end else if (r < 66) begin
            m     = MODE_FREE_ONE;
            frame = $urandom_range(0, TOTAL_FRAMES - 1);
            a     = frame_addr(frame, $urandom_range(0, 4095));
            c     = COUNT_W'($urandom);
        end else if (r < 88) begin
            m     = MODE_FREE_RUN;
            c     = ($urandom_range(0, 19) == 0) ? COUNT_W'($urandom_range(257, 4096))
                                                 : COUNT_W'($urandom_range(1, 256));
            frame = $urandom_range(0, TOTAL_FRAMES - int'(c));
            a     = frame_addr(frame, $urandom_range(0, 4095));
        end else begin
            m = t_mode'($urandom_range(0, 3));
            a = $urandom;
            c = COUNT_W'($urandom);
        end
    endtask

    initial begin
        t_mode              m;
        logic [ADDR_W-1:0]  a;
        logic [COUNT_W-1:0] c;
        start     <= 1'b0;
        i_mode    <= MODE_ALLOC;
        i_address <= '0;
        i_count   <= '0;
        i_rst_n   <= 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: zero, oversize and exact-fit counts, range ends, frame 0, odd mode
        issue(MODE_ALLOC,    '0, 16'd0, pick_gap(0));
        issue(MODE_ALLOC,    '0, 16'hFFFF, pick_gap(0));
        issue(MODE_ALLOC,    '0, 16'd32768, pick_gap(0));
        issue(MODE_ALLOC,    '0, 16'd16384, pick_gap(0));
        issue(MODE_ALLOC,    '0, 16'd1, pick_gap(0));
        issue(MODE_FREE_RUN, frame_addr(16384, 0), 16'd16384, pick_gap(0));
        issue(MODE_FREE_ONE, '0, 16'd1, pick_gap(0));
        issue(MODE_FREE_RUN, '0, 16'd5, pick_gap(0));
        issue(MODE_FREE_RUN, frame_addr(1, 0), 16'd0, pick_gap(0));
        issue(MODE_RESERVED, frame_addr(2, 0), 16'd1, pick_gap(0));
        issue(MODE_FREE_ONE, 32'hFFFF_FFFF, 16'hFFFF, pick_gap(0));
        issue(MODE_FREE_ONE, 32'h8000_0000, 16'd1, pick_gap(0));
        issue(MODE_FREE_ONE, frame_addr(0, 4095), 16'd1, pick_gap(0));
        issue(MODE_ALLOC,    '0, 16'd1, pick_gap(0));
        issue(MODE_FREE_ONE, frame_addr(0, 'h123), 16'd0, pick_gap(0));
        issue(MODE_FREE_ONE, frame_addr(0, 1), 16'd1, pick_gap(0));
        issue(MODE_FREE_RUN, frame_addr(TOTAL_FRAMES - 1, 0), 16'd1, pick_gap(0));
        issue(MODE_FREE_RUN, frame_addr(TOTAL_FRAMES - 1, 0), 16'd2, pick_gap(0));
        issue(MODE_FREE_RUN, 32'hFFFF_F000, 16'hFFFF, pick_gap(0));
        issue(MODE_FREE_RUN, frame_addr(1, 0), 16'd32767, pick_gap(0));
        issue(MODE_ALLOC,    32'hFFFF_FFFF, 16'd32768, pick_gap(0));
        issue(MODE_FREE_RUN, frame_addr(0, 'h800), 16'd32768, pick_gap(0));
        issue(MODE_ALLOC,    '0, 16'd16384, pick_gap(0));
        issue(MODE_ALLOC,    '0, 16'd3, pick_gap(0));
        drain_replies();

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i == RANDOM_ITEMS / 2) drain_replies();
            pick_request(m, a, c);
            issue(m, a, c, pick_gap(i));
        end

        drain_replies();
        repeat (20) @(posedge i_clk);
        if (mismatches == 0 && outstanding == 0) begin
            $display("** bitmap_page_frame_allocator_unit: PASSED **");
        end else begin
            $display("** bitmap_page_frame_allocator_unit: FAILED **");
        end
        $finish;
    end

endmodule
